>>> rtl/core/sfx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfx_pkg
// Shared types and constants of the sound-effect sample player: command codes,
// controller states, the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package sfx_pkg;

  // Command codes carried on the input item
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_code_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_WRITE,
    ST_START_ISSUE,
    ST_START_TIME,
    ST_TICK_ADV,
    ST_TICK_FETCH,
    ST_EMIT
  } state_e;

  // Address reduction: one compare-subtract per step, quotient below 256
  localparam int MOD_STEPS = 8;
  localparam int MOD_CNT_W = 3;

  localparam int TIME_W  = 42;
  localparam int PHASE_W = 24;

  localparam logic [15:0]        PERIOD_UNIT  = 16'd48000;
  localparam logic [PHASE_W-1:0] PHASE_STEP   = 24'd1000000;
  localparam logic [PHASE_W-1:0] PERIOD_RESET = 24'd6144000;  // rate byte 128
  localparam logic [7:0]         SILENCE_BYTE = 8'd128;
  localparam logic [15:0]        SAMPLE_MAX   = 16'h7FFF;
  localparam logic [15:0]        SAMPLE_MIN   = 16'h8000;

  typedef struct packed {
    logic load;         // latch the accepted item
    logic mod_step;     // one step of address reduction
    logic mem_write;    // store the data byte
    logic start_issue;  // begin an effect, read its first byte
    logic start_time;   // load remaining time
    logic tick_adv;     // mix, advance phase and time
    logic fetch;        // read the next byte
    logic emit;         // load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic time_nz;
    logic prio;
    logic phase_gt;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/core/sfx_sample_dma_player_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfx_sample_dma_player_top
// 8-bit unsigned PCM sound-effect player with byte sample memory, phase
// accumulator byte stepping and saturating mix with a music sample pair.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  ------------------------------
//   in       sink       in_valid_i / in_stall_o   command, address, data_byte,
//                                                 rate_byte, sound_length,
//                                                 high_priority, music_left/right
//   out      source     out_valid_o / out_stall_i left/right_sample,
//                                                 effect_active
//
// Sequencing: one item at a time. A write or a start first reduces the address
// modulo the memory depth, one compare-subtract per step. A tick fetches at
// most 21 bytes, one memory read per cycle through the single read port.
// Reset: asynchronous, active low; the memory itself is not cleared.
// Stalls: the output register holds one result; the next tick stops before
// its hand-off while that result is still stalled, other items pass freely.
//
module sfx_sample_dma_player_top
  import sfx_pkg::*;
#(
  parameter int SAMPLE_MEMORY_DEPTH = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [7:0]  rate_byte_i,
  input  wire logic [16:0] sound_length_i,
  input  wire logic        high_priority_i,
  input  wire logic [15:0] music_left_i,
  input  wire logic [15:0] music_right_i,
  // result items
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      left_sample_o,
  output logic [15:0]      right_sample_o,
  output logic             effect_active_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Sequencer: decode the item, drop low-priority starts while a
  // high-priority effect plays, walk the datapath through each command.
  sfx_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .command_i       (command_i),
    .high_priority_i (high_priority_i),
    .in_stall_o      (in_stall_o),
    .status_i        (dp_status),
    .cmd_o           (dp_cmd)
  );

  // Datapath: memory, phase and time registers, mixer, output register.
  sfx_dp #(
    .DEPTH (SAMPLE_MEMORY_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .address_i       (address_i),
    .data_byte_i     (data_byte_i),
    .rate_byte_i     (rate_byte_i),
    .sound_length_i  (sound_length_i),
    .high_priority_i (high_priority_i),
    .music_left_i    (music_left_i),
    .music_right_i   (music_right_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .left_sample_o   (left_sample_o),
    .right_sample_o  (right_sample_o),
    .effect_active_o (effect_active_o)
  );

endmodule
`default_nettype wire

>>> rtl/core/sfx_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/core/sfx_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfx_ctrl
// Sequencer of the player: decodes the accepted item and steps the datapath
// through address reduction, effect start, tick and output hand-off.
// ----------------------------------------------------------------------------
module sfx_ctrl
  import sfx_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] command_i,
  input  wire logic       high_priority_i,
  output logic            in_stall_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  state_e                 state_q, state_d;
  cmd_code_e              op_q, op_d;
  logic [MOD_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   accept;
  logic                   start_ignored;

  assign accept        = in_valid_i && (state_q == ST_IDLE);
  assign start_ignored = !high_priority_i && status_i.prio && status_i.time_nz;

  // Next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          unique case (command_i)
            CMD_TICK: begin
              state_d = ST_TICK_ADV;
            end
            CMD_START: begin
              op_d = CMD_START;
              if (!start_ignored) begin
                state_d = ST_MOD;
              end
            end
            CMD_WRITE: begin
              op_d    = CMD_WRITE;
              state_d = ST_MOD;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_MOD: begin
        cnt_d = cnt_q + MOD_CNT_W'(1);
        if (cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
          state_d = (op_q == CMD_WRITE) ? ST_WRITE : ST_START_ISSUE;
        end
      end
      ST_WRITE:       state_d = ST_IDLE;
      ST_START_ISSUE: state_d = ST_START_TIME;
      ST_START_TIME:  state_d = ST_IDLE;
      ST_TICK_ADV:    state_d = ST_TICK_FETCH;
      ST_TICK_FETCH: begin
        if (!status_i.phase_gt) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE:        cmd_o.load        = accept;
      ST_MOD:         cmd_o.mod_step    = 1'b1;
      ST_WRITE:       cmd_o.mem_write   = 1'b1;
      ST_START_ISSUE: cmd_o.start_issue = 1'b1;
      ST_START_TIME:  cmd_o.start_time  = 1'b1;
      ST_TICK_ADV:    cmd_o.tick_adv    = 1'b1;
      ST_TICK_FETCH:  cmd_o.fetch       = status_i.phase_gt;
      ST_EMIT:        cmd_o.emit        = status_i.out_free;
      default:        cmd_o             = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= CMD_TICK;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
    end
  end

  // Time load always follows the first-byte read of a start
  a_start_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start_time |-> $past(cmd_o.start_issue))
    else $error("remaining time loaded without a start");

  // Address reduction runs exactly its step count before the memory access
  a_mod_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.mem_write || cmd_o.start_issue) |->
      $past(cnt_q) == MOD_CNT_W'(MOD_STEPS - 1))
    else $error("memory access before address reduction finished");

  // One datapath command per cycle at most
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

endmodule
`default_nettype wire

>>> rtl/core/sfx_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfx_dp
// Datapath of the player: item latch, address reduction, sample memory,
// phase accumulator, remaining-time counter, mixer and output register.
// ----------------------------------------------------------------------------
module sfx_dp
  import sfx_pkg::*;
#(
  parameter int DEPTH = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_status_t       status_o,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [7:0]  rate_byte_i,
  input  wire logic [16:0] sound_length_i,
  input  wire logic        high_priority_i,
  input  wire logic [15:0] music_left_i,
  input  wire logic [15:0] music_right_i,
  input  wire logic        out_stall_i,
  output logic             out_valid_o,
  output logic [15:0]      left_sample_o,
  output logic [15:0]      right_sample_o,
  output logic             effect_active_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int MW = AW + MOD_STEPS;
  localparam logic [MW-1:0] DIV_INIT = MW'(DEPTH) << (MOD_STEPS - 1);
  localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);

  // Latched item
  logic [15:0] addr_q;
  logic [7:0]  data_q, rate_q;
  logic [16:0] len_q;
  logic        hp_q;
  logic [15:0] mus_l_q, mus_r_q;

  // Address reduction
  logic [15:0]   rem_q, rem_d;
  logic [MW-1:0] div_q, div_d;
  logic          rem_ge;
  logic [AW-1:0] rem_idx;

  // Player state
  logic [TIME_W-1:0]  time_q, time_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [PHASE_W-1:0] period_q, period_d;
  logic [15:0]        ptr_q, ptr_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [7:0]         cur_q, cur_d;
  logic               prio_q, prio_d;
  logic               pend_q, pend_d;

  // Pointer step
  logic [15:0]   base_ptr;
  logic [AW-1:0] base_idx;

  // Mix and output
  logic [15:0] fx;
  logic [16:0] sum_l, sum_r;
  logic [15:0] mix_l_q, mix_r_q, mix_l_d, mix_r_d;
  logic [15:0] out_l_q, out_r_q;
  logic        out_act_q;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  rdata;

  assign rem_ge  = MW'(rem_q) >= div_q;
  assign rem_idx = AW'(rem_q);

  always_comb begin
    rem_d = rem_q;
    div_d = div_q;
    if (cmd_i.load) begin
      rem_d = address_i;
      div_d = DIV_INIT;
    end else if (cmd_i.mod_step) begin
      if (rem_ge) begin
        rem_d = rem_q - 16'(div_q);
      end
      div_d = div_q >> 1;
    end
  end

  // Advance pointer and memory index together; both wrap
  always_comb begin
    if (cmd_i.start_issue) begin
      base_ptr = addr_q;
      base_idx = rem_idx;
    end else begin
      base_ptr = ptr_q;
      base_idx = idx_q;
    end
  end

  sfx_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_write),
    .waddr_i (rem_idx),
    .wdata_i (data_q),
    .re_i    (cmd_i.start_issue || cmd_i.fetch),
    .raddr_i (base_idx),
    .rdata_o (rdata)
  );

  // 256*(byte-128): flip the top bit, shift up a byte
  assign fx    = time_q != '0 ? {~cur_q[7], cur_q[6:0], 8'h00} : 16'h0000;
  assign sum_l = {fx[15], fx} + {mus_l_q[15], mus_l_q};
  assign sum_r = {fx[15], fx} + {mus_r_q[15], mus_r_q};

  always_comb begin
    mix_l_d = sum_l[15:0];
    if (sum_l[16] != sum_l[15]) begin
      mix_l_d = sum_l[16] ? SAMPLE_MIN : SAMPLE_MAX;
    end
    mix_r_d = sum_r[15:0];
    if (sum_r[16] != sum_r[15]) begin
      mix_r_d = sum_r[16] ? SAMPLE_MIN : SAMPLE_MAX;
    end
  end

  always_comb begin
    time_d   = time_q;
    phase_d  = phase_q;
    period_d = period_q;
    ptr_d    = ptr_q;
    idx_d    = idx_q;
    prio_d   = prio_q;
    pend_d   = cmd_i.start_issue || cmd_i.fetch;
    cur_d    = pend_q ? rdata : cur_q;
    if (cmd_i.start_issue || cmd_i.fetch) begin
      ptr_d = base_ptr + 16'd1;
      idx_d = (base_ptr == 16'hFFFF || base_idx == IDX_LAST) ? '0 : base_idx + AW'(1);
    end
    if (cmd_i.start_issue) begin
      period_d = PHASE_W'(PERIOD_UNIT) * PHASE_W'(9'd256 - {1'b0, rate_q});
      phase_d  = '0;
      prio_d   = hp_q;
    end
    if (cmd_i.start_time) begin
      time_d = TIME_W'(period_q) * TIME_W'(len_q);
    end
    if (cmd_i.tick_adv && time_q != '0) begin
      phase_d = phase_q + PHASE_STEP;
      time_d  = (time_q > TIME_W'(PHASE_STEP)) ? time_q - TIME_W'(PHASE_STEP) : '0;
    end
    if (cmd_i.fetch) begin
      phase_d = phase_q - period_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      phase_q     <= '0;
      period_q    <= PERIOD_RESET;
      ptr_q       <= '0;
      idx_q       <= '0;
      cur_q       <= SILENCE_BYTE;
      prio_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      time_q      <= time_d;
      phase_q     <= phase_d;
      period_q    <= period_d;
      ptr_q       <= ptr_d;
      idx_q       <= idx_d;
      cur_q       <= cur_d;
      prio_q      <= prio_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    if (cmd_i.load) begin
      addr_q  <= address_i;
      data_q  <= data_byte_i;
      rate_q  <= rate_byte_i;
      len_q   <= sound_length_i;
      hp_q    <= high_priority_i;
      mus_l_q <= music_left_i;
      mus_r_q <= music_right_i;
    end
    if (cmd_i.tick_adv) begin
      mix_l_q <= mix_l_d;
      mix_r_q <= mix_r_d;
    end
    if (cmd_i.emit) begin
      out_l_q   <= mix_l_q;
      out_r_q   <= mix_r_q;
      out_act_q <= time_q != '0;
    end
  end

  assign status_o.time_nz  = time_q != '0;
  assign status_o.prio     = prio_q;
  assign status_o.phase_gt = phase_q > period_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign left_sample_o   = out_l_q;
  assign right_sample_o  = out_r_q;
  assign effect_active_o = out_act_q;

  a_fetch_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fetch |-> phase_q > period_q)
    else $error("byte fetched while phase within period");

  a_emit_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> phase_q <= period_q)
    else $error("result sent before fetch loop settled");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.tick_adv && time_q == '0) |=> (time_q == '0 && $stable(phase_q)))
    else $error("idle tick moved phase or time");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mem_write || cmd_i.start_issue) |-> 32'(rem_q) < DEPTH)
    else $error("reduced address out of memory range");

endmodule
`default_nettype wire

>>> bench/sfx_sample_dma_player_top_tb.sv
// ----------------------------------------------------------------------------
// sfx_sample_dma_player_top_tb
// Self-checking bench for the sound-effect sample player. A queue of items
// (writes, starts, ticks, unused codes) is filled up front and fed through
// the valid/stall input channel in random bursts. Each accepted item runs
// through a local voice model, and every mixed sample that leaves the block
// is checked against it.
// ----------------------------------------------------------------------------
module sfx_sample_dma_player_top_tb;
  import sfx_pkg::*;

  // Phase units of one byte period per step of (256 - rate), phase per tick
  localparam int unsigned BYTE_UNIT = 48000;
  localparam int unsigned TICK_STEP = 1000000;
  // Code the block must ignore without a result
  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  // Cycles without any handshake before the run is declared hung
  localparam int          IDLE_LIMIT = 4000;
  // Items to plan in all, directed part and memory fills included
  localparam int          RANDOM_ITEMS = 600;

  typedef struct packed {
    logic        hold;           // pause marker, not sent to the block
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  rate_byte;
    logic [16:0] sound_length;
    logic        high_priority;
    logic [15:0] music_left;
    logic [15:0] music_right;
  } pcm_item_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        active;
  } mix_t;

  // Playback state of the single effect voice
  typedef struct packed {
    logic [41:0] time_left;
    logic [31:0] phase;
    logic [15:0] rd_ptr;
    logic [7:0]  cur_byte;
    logic [7:0]  rate;
    logic        prio;
  } voice_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PULSE,
    RX_BLOCKS
  } rx_mode_e;

  logic        clk_i;
  logic        rst_ni;

  logic        in_valid = 1'b0;
  logic        in_stall;
  pcm_item_t   cur_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] left_sample;
  logic [15:0] right_sample;
  logic        effect_active;

  // Sample memory as the checker sees it, and which entries the stimulus
  // has already written (used while planning, so no tick reads garbage)
  logic [7:0]  sfx_mem [65536];
  bit          sfx_written [65536];

  voice_t      plan_voice;
  voice_t      live_voice;
  pcm_item_t   item_pend_q [$];
  mix_t        mix_expected_q [$];

  int          planned_cnt  = 0;
  int          accepted_cnt = 0;
  int          fail_cnt     = 0;
  int          burst_left   = 0;
  int          gap_left     = 0;
  int          idle_cnt     = 0;
  logic [31:0] rx_cnt       = '0;
  rx_mode_e    rx_mode      = RX_OPEN;

  sfx_sample_dma_player_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (cur_item.command),
    .address_i       (cur_item.address),
    .data_byte_i     (cur_item.data_byte),
    .rate_byte_i     (cur_item.rate_byte),
    .sound_length_i  (cur_item.sound_length),
    .high_priority_i (cur_item.high_priority),
    .music_left_i    (cur_item.music_left),
    .music_right_i   (cur_item.music_right),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .left_sample_o   (left_sample),
    .right_sample_o  (right_sample),
    .effect_active_o (effect_active)
  );

  // --------------------------------------------------------------------------
  // Voice model
  // --------------------------------------------------------------------------

  function automatic logic [15:0] clip16(input int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Read the byte under the read pointer and advance it. While planning,
  // only note the first address that has not been written yet.
  function automatic void fetch_byte(inout voice_t v, input bit planning,
                                     inout bit unsafe, inout logic [15:0] bad_addr);
    if (planning) begin
      if (!sfx_written[v.rd_ptr] && !unsafe) begin
        unsafe   = 1'b1;
        bad_addr = v.rd_ptr;
      end
      v.cur_byte = SILENCE_BYTE;
    end else begin
      v.cur_byte = sfx_mem[v.rd_ptr];
    end
    v.rd_ptr = v.rd_ptr + 16'd1;
  endfunction

  // Apply one item to a voice; a tick yields one mixed sample pair.
  function automatic void voice_step(inout voice_t v, input pcm_item_t it,
                                     input bit planning, output mix_t res,
                                     output bit has_res, output bit unsafe,
                                     output logic [15:0] bad_addr);
    longint unsigned span;
    int unsigned     period;
    int              fx;
    int              ml;
    int              mr;
    res      = '0;
    has_res  = 1'b0;
    unsafe   = 1'b0;
    bad_addr = '0;
    case (it.command)
      CMD_WRITE: begin
        if (planning) sfx_written[it.address] = 1'b1;
        else sfx_mem[it.address] = it.data_byte;
      end
      CMD_START: begin
        // a low-priority start cannot cut into a busy high-priority effect
        if (it.high_priority || !v.prio || v.time_left == '0) begin
          span = 64'(BYTE_UNIT) * (64'd256 - 64'(it.rate_byte)) * 64'(it.sound_length);
          v.rate      = it.rate_byte;
          v.time_left = span[41:0];
          v.phase     = '0;
          v.rd_ptr    = it.address;
          fetch_byte(v, planning, unsafe, bad_addr);
          v.prio      = it.high_priority;
        end
      end
      CMD_TICK: begin
        fx = 0;
        if (v.time_left != '0) begin
          period  = BYTE_UNIT * (32'd256 - 32'(v.rate));
          fx      = 256 * (int'(v.cur_byte) - 128);
          v.phase = v.phase + TICK_STEP;
          while (v.phase > period) begin
            fetch_byte(v, planning, unsafe, bad_addr);
            v.phase = v.phase - period;
          end
          if (v.time_left > 42'(TICK_STEP)) v.time_left = v.time_left - 42'(TICK_STEP);
          else v.time_left = '0;
        end
        ml         = int'($signed(it.music_left));
        mr         = int'($signed(it.music_right));
        res.left   = clip16(fx + ml);
        res.right  = clip16(fx + mr);
        res.active = (v.time_left != '0);
        has_res    = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Item construction and planning
  // --------------------------------------------------------------------------

  // Every payload field random so that unused fields still toggle
  function automatic pcm_item_t blank_item(input logic [1:0] cmd);
    pcm_item_t it;
    it.hold          = 1'b0;
    it.command       = cmd;
    it.address       = 16'($urandom);
    it.data_byte     = 8'($urandom);
    it.rate_byte     = 8'($urandom);
    it.sound_length  = 17'($urandom);
    it.high_priority = 1'($urandom);
    it.music_left    = 16'($urandom);
    it.music_right   = 16'($urandom);
    return it;
  endfunction

  function automatic pcm_item_t write_item(input logic [15:0] addr, input logic [7:0] data);
    pcm_item_t it;
    it           = blank_item(CMD_WRITE);
    it.address   = addr;
    it.data_byte = data;
    return it;
  endfunction

  function automatic pcm_item_t start_item(input logic [15:0] addr, input logic [7:0] rate,
                                           input logic [16:0] len, input logic hp);
    pcm_item_t it;
    it               = blank_item(CMD_START);
    it.address       = addr;
    it.rate_byte     = rate;
    it.sound_length  = len;
    it.high_priority = hp;
    return it;
  endfunction

  function automatic pcm_item_t tick_item(input logic [15:0] ml, input logic [15:0] mr);
    pcm_item_t it;
    it             = blank_item(CMD_TICK);
    it.music_left  = ml;
    it.music_right = mr;
    return it;
  endfunction

  function automatic pcm_item_t hold_item();
    pcm_item_t it;
    it      = '0;
    it.hold = 1'b1;
    return it;
  endfunction

  function automatic logic [15:0] pick_music();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Queue an item; first fill any memory entry it would read unwritten
  function automatic void plan_item(input pcm_item_t it);
    voice_t      trial;
    mix_t        res;
    bit          has_res;
    bit          unsafe;
    logic [15:0] bad_addr;
    pcm_item_t   fill;
    if (it.hold) begin
      item_pend_q.push_back(it);
      return;
    end
    do begin
      trial = plan_voice;
      voice_step(trial, it, 1'b1, res, has_res, unsafe, bad_addr);
      if (unsafe) begin
        fill = write_item(bad_addr, 8'($urandom));
        sfx_written[bad_addr] = 1'b1;
        item_pend_q.push_back(fill);
        planned_cnt++;
      end
    end while (unsafe);
    plan_voice = trial;
    item_pend_q.push_back(it);
    planned_cnt++;
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Driver: present queued items in bursts; model each item as it is taken
  // --------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    pcm_item_t   nxt;
    mix_t        res;
    bit          has_res;
    bit          unsafe;
    logic [15:0] bad_addr;
    bit          took;
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      cur_item   <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      took = 1'b0;
      if (in_valid && !in_stall) begin
        voice_step(live_voice, cur_item, 1'b0, res, has_res, unsafe, bad_addr);
        if (has_res) mix_expected_q.push_back(res);
        accepted_cnt++;
        took = 1'b1;
      end
      // a stalled item stays on the bus untouched
      if (!in_valid || took) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (item_pend_q.size() != 0 && item_pend_q[0].hold) begin
          // hold off until every expected sample has come out
          in_valid <= 1'b0;
          if (mix_expected_q.size() == 0) void'(item_pend_q.pop_front());
        end else if (item_pend_q.size() != 0) begin
          nxt      = item_pend_q.pop_front();
          cur_item <= nxt;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            // pick the next burst and the gap that ends the current one
            case ($urandom_range(0, 9))
              0, 1, 2: begin
                burst_left <= $urandom_range(1, 24);
                gap_left   <= 0;
              end
              8: begin
                burst_left <= $urandom_range(1, 24);
                gap_left   <= $urandom_range(10, 40);
              end
              9: begin
                burst_left <= $urandom_range(50, 120);
                gap_left   <= 0;
              end
              default: begin
                burst_left <= $urandom_range(1, 24);
                gap_left   <= $urandom_range(1, 6);
              end
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each sample taken, then stall on a pattern of its own
  // --------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : check_samples
    mix_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      rx_cnt    <= '0;
      rx_mode   <= RX_OPEN;
    end else begin
      if (out_valid && !out_stall) begin
        if (mix_expected_q.size() == 0) begin
          $error("unexpected sample: left %h right %h active %b",
                 left_sample, right_sample, effect_active);
          fail_cnt++;
        end else begin
          want = mix_expected_q.pop_front();
          if (left_sample !== want.left) begin
            $error("left_sample: expected %h, got %h", want.left, left_sample);
            fail_cnt++;
          end
          if (right_sample !== want.right) begin
            $error("right_sample: expected %h, got %h", want.right, right_sample);
            fail_cnt++;
          end
          if (effect_active !== want.active) begin
            $error("effect_active: expected %b, got %b", want.active, effect_active);
            fail_cnt++;
          end
        end
      end
      // switch the stall style each time the low byte of rx_cnt is zero
      rx_cnt <= rx_cnt + 1;
      if (rx_cnt[7:0] == 8'd0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_COIN:   out_stall <= 1'($urandom);
        RX_PULSE:  out_stall <= (rx_cnt[2:0] != 3'd0);
        RX_BLOCKS: out_stall <= rx_cnt[5];
        default:   out_stall <= 1'b0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves for too long
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cnt <= 0;
      end else if (idle_cnt >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------

  initial begin : stimulus
    int          n_ticks;
    int          n_fill;
    bit          held_mid;
    logic [15:0] base;
    logic [7:0]  rate;
    logic [16:0] len;
    plan_voice = '{time_left: '0, phase: '0, rd_ptr: '0, cur_byte: SILENCE_BYTE,
                   rate: 8'd128, prio: 1'b0};
    live_voice = plan_voice;

    // Directed: idle ticks at the mix extremes
    plan_item(tick_item(16'h7FFF, 16'h8000));
    plan_item(tick_item(16'h8000, 16'h7FFF));
    // memory extremes, including the last address for the pointer wrap
    plan_item(write_item(16'h0000, 8'h00));
    plan_item(write_item(16'h0001, 8'hFF));
    plan_item(write_item(16'h0002, 8'h80));
    plan_item(write_item(16'hFFFF, 8'hFF));
    // unused command code: dropped without a result
    plan_item(blank_item(CMD_UNUSED));
    // fastest rate, full negative byte plus negative music saturates low;
    // the effect ends on that tick, so the next one passes full positive music
    plan_item(start_item(16'h0000, 8'd255, 17'd3, 1'b0));
    plan_item(tick_item(16'h8000, 16'h8000));
    plan_item(tick_item(16'h7FFF, 16'h7FFF));
    // slowest rate, high priority, long effect that wraps the pointer
    plan_item(start_item(16'hFFFF, 8'd0, 17'd65536, 1'b1));
    plan_item(tick_item(16'h0000, 16'h0000));
    plan_item(tick_item(16'h7FFF, 16'h0000));
    // low priority while a high-priority effect is busy: ignored
    plan_item(start_item(16'h0002, 8'd128, 17'd4, 1'b0));
    plan_item(tick_item(16'h0000, 16'h8000));
    // zero length: the start lands but the voice is idle at once
    plan_item(start_item(16'h0001, 8'd255, 17'd0, 1'b1));
    plan_item(tick_item(pick_music(), pick_music()));
    // length beyond 65536 uses the full field
    plan_item(start_item(16'h0000, 8'd255, 17'h1FFFF, 1'b0));
    plan_item(tick_item(pick_music(), pick_music()));
    // low priority over a low-priority effect takes over
    plan_item(start_item(16'h0001, 8'd200, 17'd2, 1'b0));
    plan_item(tick_item(pick_music(), pick_music()));
    plan_item(tick_item(pick_music(), pick_music()));
    plan_item(tick_item(pick_music(), pick_music()));
    plan_item(hold_item());

    // Random: mostly start-and-play sequences, some noise in between
    held_mid = 1'b0;
    while (planned_cnt < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) < 14) begin
        base = ($urandom_range(0, 7) == 0) ? 16'hFFF0 + 16'($urandom_range(0, 15))
                                           : 16'($urandom);
        n_fill = $urandom_range(0, 3);
        for (int i = 0; i < n_fill; i++) begin
          plan_item(write_item(base + 16'(i), 8'($urandom)));
        end
        case ($urandom_range(0, 7))
          0:       rate = 8'd0;
          1:       rate = 8'd255;
          default: rate = 8'($urandom);
        endcase
        case ($urandom_range(0, 15))
          0:       len = 17'($urandom_range(1, 65536));
          1:       len = 17'd65536;
          default: len = 17'($urandom_range(1, 6));
        endcase
        plan_item(start_item(base, rate, len, 1'($urandom)));
        n_ticks = $urandom_range(1, 30);
        for (int i = 0; i < n_ticks; i++) begin
          plan_item(tick_item(pick_music(), pick_music()));
        end
      end else begin
        case ($urandom_range(0, 3))
          0:       plan_item(tick_item(pick_music(), pick_music()));
          1:       plan_item(write_item(16'($urandom), 8'($urandom)));
          2:       plan_item(blank_item(CMD_UNUSED));
          default: plan_item(start_item(16'($urandom), 8'($urandom),
                                        17'($urandom_range(1, 6)), 1'b0));
        endcase
      end
      if (!held_mid && planned_cnt >= RANDOM_ITEMS / 2) begin
        plan_item(hold_item());
        held_mid = 1'b1;
      end
    end

    // Wait for every item to be taken and every sample to come out
    while (accepted_cnt != planned_cnt || mix_expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (60) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/sfx_pkg.sv
rtl/core/sfx_ram.sv
rtl/core/sfx_ctrl.sv
rtl/core/sfx_dp.sv
rtl/core/sfx_sample_dma_player_top.sv
bench/sfx_sample_dma_player_top_tb.sv
